FILE: sv/space_time_grid_interpolator_macros.svh
// ---------------------------------------------------------------------------
// Space-time grid interpolator assertion macros
// Shared concurrent assertion forms for the interpolator RTL.
// ---------------------------------------------------------------------------
`ifndef SPACE_TIME_GRID_INTERPOLATOR_MACROS_SVH
`define SPACE_TIME_GRID_INTERPOLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STGI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STGI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/stgi_pkg.sv
// ---------------------------------------------------------------------------
// Space-time grid interpolator package
// Field widths, register map, reset values and datapath widths.
// ---------------------------------------------------------------------------
package stgi_pkg;

  localparam int GRID_Y_DEF = 64;
  localparam int GRID_Z_DEF = 64;
  localparam int NV_DEF     = 3;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = 16;
  localparam int GIDX_W   = 6;
  localparam int COMP_W   = 2;
  localparam int PIDX_W   = 7;
  localparam int CFG_W    = 24;
  localparam int INV_W    = 18;
  localparam int VALUE_W  = 20;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam int POS_W   = PIDX_W + CFG_W;
  localparam int IPART_W = POS_W - FRAC_W;
  localparam int ROW_W   = 2 * SAMPLE_W + 1;
  localparam int CUR_W   = ROW_W;
  localparam int BLEND_W = ROW_W + FRAC_W + 2;
  localparam int SCALE_W = CUR_W + INV_W + 2;

  localparam logic [2:0] REG_STEP_Y   = 3'd0;
  localparam logic [2:0] REG_STEP_Z   = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd3;
  localparam logic [2:0] REG_INV      = 3'd4;

  localparam logic [CFG_W-1:0] STEP_RST   = CFG_W'(32'h0001_0000);
  localparam logic [CFG_W-1:0] ORIGIN_RST = '0;
  localparam logic [INV_W-1:0] INV_RST    = INV_W'(32'h0001_0000);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

FILE: sv/space_time_grid_interpolator.sv
// ---------------------------------------------------------------------------
// Space-time grid interpolator
// Bilinear blend of two stored grid frames, linear blend in time, scaling.
// ---------------------------------------------------------------------------
// A sample write is accepted only while idle. A query gives one result per
// component and frees the block as its last result is shown; the single frame
// memory port serves 8 reads a component.
// Reset restores the register defaults and idles the sequencer; the frame
// memory is not cleared and holds garbage until written.
`include "space_time_grid_interpolator_macros.svh"

module space_time_grid_interpolator #(
  parameter int GRID_Y = stgi_pkg::GRID_Y_DEF,
  parameter int GRID_Z = stgi_pkg::GRID_Z_DEF,
  parameter int NV     = stgi_pkg::NV_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                opcode_i,
  input  logic                                frame_sel_i,
  input  logic [stgi_pkg::GIDX_W-1:0]         grid_y_i,
  input  logic [stgi_pkg::GIDX_W-1:0]         grid_z_i,
  input  logic [stgi_pkg::COMP_W-1:0]         component_i,
  input  logic signed [stgi_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [stgi_pkg::PIDX_W-1:0]         point_j_i,
  input  logic [stgi_pkg::PIDX_W-1:0]         point_k_i,
  input  logic [stgi_pkg::FRAC_W-1:0]         time_frac_i,
  output logic                                out_valid_o,
  output logic [stgi_pkg::COMP_W-1:0]         out_component_o,
  output logic signed [stgi_pkg::VALUE_W-1:0] value_o,
  output logic                                edge_flag_o,
  output logic                                last_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stgi_pkg::APB_AW-1:0]         paddr,
  input  logic [stgi_pkg::APB_DW-1:0]         pwdata,
  output logic [stgi_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int FRAME_OFS = GRID_Y * GRID_Z * NV;
  localparam int DEPTH     = 2 * FRAME_OFS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int YW        = $clog2(GRID_Y);
  localparam int ZW        = $clog2(GRID_Z);
  localparam int SW        = stgi_pkg::SAMPLE_W;
  localparam int FW        = stgi_pkg::FRAC_W;
  localparam int RW        = stgi_pkg::ROW_W;
  localparam int CW        = stgi_pkg::CUR_W;
  localparam int BW        = stgi_pkg::BLEND_W;
  localparam int DW        = stgi_pkg::SCALE_W;
  localparam int VW        = stgi_pkg::VALUE_W;
  localparam int IW        = stgi_pkg::IPART_W;
  localparam int PW        = stgi_pkg::POS_W;
  localparam int KW        = stgi_pkg::COMP_W;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_IDX  = 2'd1;
  localparam logic [1:0] PH_RD   = 2'd2;
  localparam logic [1:0] PH_WAIT = 2'd3;

  localparam logic [2:0]    NB_LAST   = 3'b111;
  localparam logic [KW-1:0] COMP_LAST = KW'(NV - 1);
  localparam logic [IW:0]   YLIM      = (IW + 1)'(GRID_Y - 1);
  localparam logic [IW:0]   ZLIM      = (IW + 1)'(GRID_Z - 1);
  localparam logic [BW-1:0] HALF_B    = {{(BW - FW){1'b0}}, 1'b1, {(FW - 1){1'b0}}};
  localparam logic [DW-1:0] HALF_D    = {{(DW - 2 * FW){1'b0}}, 1'b1, {(2 * FW - 1){1'b0}}};
  localparam logic signed [VW:0] VMAX = {2'b00, {(VW - 1){1'b1}}};
  localparam logic signed [VW:0] VMIN = {2'b11, {(VW - 1){1'b0}}};

  logic [stgi_pkg::CFG_W-1:0] step_y_q, step_z_q, origin_y_q, origin_z_q;
  logic [stgi_pkg::INV_W-1:0] inv_scale_q;
  logic                       cfg_we;

  logic [1:0]    ph_q, ph_d;
  logic [2:0]    iss_nb_q, iss_nb_d;
  logic [KW-1:0] iss_comp_q, iss_comp_d;
  logic          accept, query_acc;

  logic [PW-1:0] pos_y_q, pos_z_q;
  logic [FW-1:0] ft_q;
  logic [IW-1:0] iy, iz;
  logic [IW:0]   iy1, iz1;
  logic          clamp_y0, clamp_y1, clamp_z0, clamp_z1;
  logic [YW-1:0] y0, y1;
  logic [ZW-1:0] z0, z1;
  logic [ADDR_W-1:0] yoff0_q, yoff1_q, zoff0_q, zoff1_q;
  logic          edge_flag_q;

  logic              ram_we, wr_ok;
  logic [ADDR_W-1:0] ram_addr, rd_addr, wr_addr;
  logic [SW-1:0]     ram_rdata;

  logic          pa_vld_q;
  logic [2:0]    pa_nb_q;
  logic [KW-1:0] pa_comp_q;
  logic [SW-1:0] v0_q;
  logic signed [SW:0]     dv;
  logic signed [2*SW+1:0] dv_prod, row_full;

  logic          row_vld_q, row_zsel_q, row_frame_q;
  logic [KW-1:0] row_comp_q;
  logic [RW-1:0] row_q, r0_q;
  logic signed [RW:0]   dr;
  logic signed [BW-1:0] dr_prod, bl_sum;

  logic          bl_vld_q;
  logic [KW-1:0] bl_comp_q;
  logic [CW-1:0] cur_q, nxt_q;
  logic signed [CW:0]   dt;
  logic signed [BW-1:0] dt_prod, tb_sum;

  logic          tb_vld_q;
  logic [KW-1:0] tb_comp_q;
  logic [CW-1:0] tb_q;
  logic signed [DW-1:0] sc_prod, sc_sum;
  logic signed [VW:0]   sc_int;
  logic [VW-1:0]        value_d;

  logic          out_valid_q, out_last_q;
  logic [KW-1:0] out_comp_q;
  logic [VW-1:0] value_q;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_y_q    <= stgi_pkg::STEP_RST;
      step_z_q    <= stgi_pkg::STEP_RST;
      origin_y_q  <= stgi_pkg::ORIGIN_RST;
      origin_z_q  <= stgi_pkg::ORIGIN_RST;
      inv_scale_q <= stgi_pkg::INV_RST;
    end else if (cfg_we) begin
      case (paddr[stgi_pkg::APB_AW-1:2])
        stgi_pkg::REG_STEP_Y:   step_y_q    <= pwdata[stgi_pkg::CFG_W-1:0];
        stgi_pkg::REG_STEP_Z:   step_z_q    <= pwdata[stgi_pkg::CFG_W-1:0];
        stgi_pkg::REG_ORIGIN_Y: origin_y_q  <= pwdata[stgi_pkg::CFG_W-1:0];
        stgi_pkg::REG_ORIGIN_Z: origin_z_q  <= pwdata[stgi_pkg::CFG_W-1:0];
        stgi_pkg::REG_INV:      inv_scale_q <= pwdata[stgi_pkg::INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[stgi_pkg::APB_AW-1:2])
      stgi_pkg::REG_STEP_Y:   prdata = stgi_pkg::APB_DW'(step_y_q);
      stgi_pkg::REG_STEP_Z:   prdata = stgi_pkg::APB_DW'(step_z_q);
      stgi_pkg::REG_ORIGIN_Y: prdata = stgi_pkg::APB_DW'(origin_y_q);
      stgi_pkg::REG_ORIGIN_Z: prdata = stgi_pkg::APB_DW'(origin_z_q);
      stgi_pkg::REG_INV:      prdata = stgi_pkg::APB_DW'(inv_scale_q);
      default:                prdata = '0;
    endcase
  end

  assign busy      = (ph_q != PH_IDLE);
  assign accept    = start && !busy;
  assign query_acc = accept && (opcode_i == stgi_pkg::OP_QUERY);

  always_comb begin
    ph_d       = ph_q;
    iss_nb_d   = iss_nb_q;
    iss_comp_d = iss_comp_q;
    case (ph_q)
      PH_IDLE: begin
        if (query_acc) begin
          ph_d       = PH_IDX;
          iss_nb_d   = '0;
          iss_comp_d = '0;
        end
      end
      PH_IDX: begin
        ph_d = PH_RD;
      end
      PH_RD: begin
        iss_nb_d = iss_nb_q + 3'd1;
        if (iss_nb_q == NB_LAST) begin
          iss_comp_d = iss_comp_q + KW'(1);
          if (iss_comp_q == COMP_LAST) begin
            ph_d = PH_WAIT;
          end
        end
      end
      PH_WAIT: begin
        if (tb_vld_q && (tb_comp_q == COMP_LAST)) begin
          ph_d = PH_IDLE;
        end
      end
      default: ph_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q       <= PH_IDLE;
      iss_nb_q   <= '0;
      iss_comp_q <= '0;
    end else begin
      ph_q       <= ph_d;
      iss_nb_q   <= iss_nb_d;
      iss_comp_q <= iss_comp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_acc) begin
      pos_y_q <= PW'(point_j_i) * PW'(step_y_q) + PW'(origin_y_q);
      pos_z_q <= PW'(point_k_i) * PW'(step_z_q) + PW'(origin_z_q);
      ft_q    <= time_frac_i;
    end
  end

  assign iy       = pos_y_q[PW-1:FW];
  assign iz       = pos_z_q[PW-1:FW];
  assign iy1      = {1'b0, iy} + (IW + 1)'(1);
  assign iz1      = {1'b0, iz} + (IW + 1)'(1);
  assign clamp_y0 = ({1'b0, iy} > YLIM);
  assign clamp_y1 = (iy1 > YLIM);
  assign clamp_z0 = ({1'b0, iz} > ZLIM);
  assign clamp_z1 = (iz1 > ZLIM);
  assign y0       = clamp_y0 ? YW'(GRID_Y - 1) : iy[YW-1:0];
  assign y1       = clamp_y1 ? YW'(GRID_Y - 1) : iy1[YW-1:0];
  assign z0       = clamp_z0 ? ZW'(GRID_Z - 1) : iz[ZW-1:0];
  assign z1       = clamp_z1 ? ZW'(GRID_Z - 1) : iz1[ZW-1:0];

  always_ff @(posedge clk_i) begin
    if (ph_q == PH_IDX) begin
      yoff0_q     <= ADDR_W'(y0 * NV);
      yoff1_q     <= ADDR_W'(y1 * NV);
      zoff0_q     <= ADDR_W'(z0 * (GRID_Y * NV));
      zoff1_q     <= ADDR_W'(z1 * (GRID_Y * NV));
      edge_flag_q <= clamp_y0 || clamp_y1 || clamp_z0 || clamp_z1;
    end
  end

  assign rd_addr = (iss_nb_q[2] ? ADDR_W'(FRAME_OFS) : '0)
                 + (iss_nb_q[1] ? zoff1_q : zoff0_q)
                 + (iss_nb_q[0] ? yoff1_q : yoff0_q)
                 + ADDR_W'(iss_comp_q);
  assign wr_addr = (frame_sel_i ? ADDR_W'(FRAME_OFS) : '0)
                 + ADDR_W'(grid_z_i * (GRID_Y * NV))
                 + ADDR_W'(grid_y_i * NV)
                 + ADDR_W'(component_i);
  assign wr_ok    = (32'(grid_y_i) < 32'(GRID_Y)) && (32'(grid_z_i) < 32'(GRID_Z))
                 && (32'(component_i) < 32'(NV));
  assign ram_we   = accept && (opcode_i == stgi_pkg::OP_WRITE) && wr_ok;
  assign ram_addr = (ph_q == PH_RD) ? rd_addr : wr_addr;

  stgi_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(sample_i),
    .rdata_o(ram_rdata)
  );

  // Neighbor order per component: y then z then frame, one read per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pa_vld_q    <= 1'b0;
      row_vld_q   <= 1'b0;
      bl_vld_q    <= 1'b0;
      tb_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pa_vld_q    <= (ph_q == PH_RD);
      row_vld_q   <= pa_vld_q && pa_nb_q[0];
      bl_vld_q    <= row_vld_q && row_zsel_q && row_frame_q;
      tb_vld_q    <= bl_vld_q;
      out_valid_q <= tb_vld_q;
    end
  end

  assign dv       = $signed({ram_rdata[SW-1], ram_rdata}) - $signed({v0_q[SW-1], v0_q});
  assign dv_prod  = dv * $signed({1'b0, pos_y_q[FW-1:0]});
  assign row_full = $signed({{2{v0_q[SW-1]}}, v0_q, {FW{1'b0}}}) + dv_prod;

  always_ff @(posedge clk_i) begin
    pa_nb_q   <= iss_nb_q;
    pa_comp_q <= iss_comp_q;
    if (pa_vld_q && !pa_nb_q[0]) begin
      v0_q <= ram_rdata;
    end
    row_q       <= row_full[RW-1:0];
    row_zsel_q  <= pa_nb_q[1];
    row_frame_q <= pa_nb_q[2];
    row_comp_q  <= pa_comp_q;
  end

  assign dr      = $signed({row_q[RW-1], row_q}) - $signed({r0_q[RW-1], r0_q});
  assign dr_prod = dr * $signed({1'b0, pos_z_q[FW-1:0]});
  assign bl_sum  = $signed({{2{r0_q[RW-1]}}, r0_q, {FW{1'b0}}}) + dr_prod + $signed(HALF_B);

  always_ff @(posedge clk_i) begin
    if (row_vld_q) begin
      if (!row_zsel_q) begin
        r0_q <= row_q;
      end else if (!row_frame_q) begin
        cur_q <= bl_sum[FW+CW-1:FW];
      end else begin
        nxt_q <= bl_sum[FW+CW-1:FW];
      end
    end
    bl_comp_q <= row_comp_q;
  end

  assign dt      = $signed({nxt_q[CW-1], nxt_q}) - $signed({cur_q[CW-1], cur_q});
  assign dt_prod = dt * $signed({1'b0, ft_q});
  assign tb_sum  = $signed({{2{cur_q[CW-1]}}, cur_q, {FW{1'b0}}}) + dt_prod + $signed(HALF_B);

  always_ff @(posedge clk_i) begin
    tb_q      <= tb_sum[FW+CW-1:FW];
    tb_comp_q <= bl_comp_q;
  end

  assign sc_prod = $signed(tb_q) * $signed({1'b0, inv_scale_q});
  assign sc_sum  = sc_prod + $signed(HALF_D);
  assign sc_int  = sc_sum[DW-1:2*FW];

  always_comb begin
    if (sc_int > VMAX) begin
      value_d = VMAX[VW-1:0];
    end else if (sc_int < VMIN) begin
      value_d = VMIN[VW-1:0];
    end else begin
      value_d = sc_int[VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    value_q    <= value_d;
    out_comp_q <= tb_comp_q;
    out_last_q <= (tb_comp_q == COMP_LAST);
  end

  assign out_valid_o     = out_valid_q;
  assign out_component_o = out_comp_q;
  assign value_o         = value_q;
  assign edge_flag_o     = edge_flag_q;
  assign last_o          = out_last_q;

  `STGI_ASSERT_SAME(a_mid_result_busy, clk_i, rst_ni, out_valid_o && !last_o, busy, "Result before the last one seen while idle.")
  `STGI_ASSERT_SAME(a_last_frees_block, clk_i, rst_ni, out_valid_o && last_o, !busy, "Block still busy when the last result is shown.")
  `STGI_ASSERT_SAME(a_no_write_in_query, clk_i, rst_ni, ram_we, ph_q == PH_IDLE, "Frame memory written while a query is in progress.")
  `STGI_ASSERT_NEXT(a_query_enters_index, clk_i, rst_ni, query_acc, ph_q == PH_IDX, "Accepted query did not enter the index phase.")

endmodule

FILE: sv/stgi_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ---------------------------------------------------------------------------
module stgi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
